@@ rtl/spectrum_trace_hold_average_assert.svh @@
// ----------------------------------------------------------------------------
// spectrum trace hold/average assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_TRACE_HOLD_AVERAGE_ASSERT_SVH
`define SPECTRUM_TRACE_HOLD_AVERAGE_ASSERT_SVH

// same-cycle implication
`define STH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sth_pkg.sv @@
// ----------------------------------------------------------------------------
// sth_pkg
// shared types and constants of the spectrum trace hold/average block
// ----------------------------------------------------------------------------
`default_nettype none

package sth_pkg;

	// fraction bits added to a sample inside the trace store
	localparam int FRAC_EXTRA = 8;

	// averaging weight, unsigned Q1.16
	localparam int ALPHA_W    = 17;
	localparam int ALPHA_FRAC = 16;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
	localparam int ALPHA_HALF = 32768;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRACE_MODE   = 2'd0,
		REG_FRAME_LENGTH = 2'd1,
		REG_AVG_ALPHA    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_LIVE     = 2'd0,
		MODE_MAX_HOLD = 2'd1,
		MODE_AVERAGE  = 2'd2
	} trace_mode_t;

	// result buffer
	localparam int OUT_PTR_W = 3;
	localparam int OUT_DEPTH = 1 << OUT_PTR_W;

	// per-bin update selection, decided when the word is taken
	typedef struct packed {
		logic use_x;     // load the sample
		logic take_max;  // keep the larger of sample and store
		logic last;      // last bin of the frame
	} item_op_t;

endpackage

`default_nettype wire

@@ rtl/sth_bin_if.sv @@
// ----------------------------------------------------------------------------
// sth_bin_if
// stream of spectrum magnitude bins, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface sth_bin_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] bin_power;

	modport source (output valid, output bin_power, input ready);
	modport sink   (input valid, input bin_power, output ready);
endinterface

`default_nettype wire

@@ rtl/sth_trace_if.sv @@
// ----------------------------------------------------------------------------
// sth_trace_if
// stream of trace results, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface sth_trace_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_BINS    = 1024
);
	localparam int IW = $clog2(MAX_BINS);

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] trace_value;
	logic [IW-1:0]                 bin_index;
	logic                          frame_last;

	modport source (output valid, output trace_value, output bin_index, output frame_last,
		input ready);
	modport sink   (input valid, input trace_value, input bin_index, input frame_last,
		output ready);
endinterface

`default_nettype wire

@@ rtl/sth_ram.sv @@
// ----------------------------------------------------------------------------
// sth_ram
// simple dual port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module sth_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

@@ rtl/sth_ctrl.sv @@
// ----------------------------------------------------------------------------
// sth_ctrl
// configuration registers, bin counter, priming flag and input handshake
// ----------------------------------------------------------------------------
`default_nettype none

module sth_ctrl #(
	parameter int MAX_BINS = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write_en,
	input  wire logic [sth_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sth_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	input  wire logic                                has_room,
	input  wire logic                                idx_busy,
	output logic                                     in_ready,
	output logic                                     accept,
	output logic [$clog2(MAX_BINS)-1:0]              cand_idx,
	output sth_pkg::item_op_t                        op,
	output logic [sth_pkg::ALPHA_W-1:0]              alpha
);
	import sth_pkg::*;

	localparam int IW = $clog2(MAX_BINS);
	localparam int LW = $clog2(MAX_BINS + 1);

	logic [IW-1:0]      cnt_q;
	logic               primed_q;
	logic [1:0]         mode_q;
	logic [LW-1:0]      len_q;
	logic [ALPHA_W-1:0] alpha_q;

	logic [LW-1:0]      len_eff;
	logic [ALPHA_W-1:0] alpha_wr;

	always_comb begin
		priority if (len_q == '0) begin
			len_eff = LW'(1);
		end else if (len_q > LW'(MAX_BINS)) begin
			len_eff = LW'(MAX_BINS);
		end else begin
			len_eff = len_q;
		end
	end

	assign cand_idx = (LW'(cnt_q) >= len_eff) ? '0 : cnt_q;

	always_comb begin
		op.use_x    = 1'b1;
		op.take_max = 1'b0;
		op.last     = (LW'(cand_idx) + LW'(1)) >= len_eff;
		if (primed_q) begin
			unique case (mode_q)
				MODE_MAX_HOLD: begin
					op.use_x    = 1'b0;
					op.take_max = 1'b1;
				end
				MODE_AVERAGE: begin
					op.use_x = 1'b0;
				end
				default: begin
					op.use_x = 1'b1;
				end
			endcase
		end
	end

	// a bin whose entry is still in the first two update stages waits
	assign in_ready = has_room && !idx_busy;
	assign accept   = in_valid && in_ready;
	assign alpha    = alpha_q;

	assign alpha_wr = (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE : cfg_data[ALPHA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			primed_q <= 1'b0;
			mode_q   <= MODE_LIVE;
			len_q    <= LW'(MAX_BINS);
			alpha_q  <= ALPHA_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_TRACE_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				REG_FRAME_LENGTH: begin
					len_q    <= cfg_data[LW-1:0];
					cnt_q    <= '0;
					primed_q <= 1'b0;
				end
				REG_AVG_ALPHA: begin
					alpha_q <= alpha_wr;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (op.last) begin
				cnt_q    <= '0;
				primed_q <= 1'b1;
			end else begin
				cnt_q <= cand_idx + IW'(1);
			end
		end
	end
endmodule

`default_nettype wire

@@ rtl/sth_update.sv @@
// ----------------------------------------------------------------------------
// sth_update
// read-modify-write pipeline around the trace store: difference, weight
// multiply, update and write back, rounding to the output format
// ----------------------------------------------------------------------------
`default_nettype none

module sth_update #(
	parameter int MAX_BINS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          accept,
	input  wire logic [$clog2(MAX_BINS)-1:0]                   cand_idx,
	input  wire sth_pkg::item_op_t                             op,
	input  wire logic signed [SAMPLE_BITS-1:0]                 bin_power,
	input  wire logic [sth_pkg::ALPHA_W-1:0]                   alpha,
	input  wire logic [SAMPLE_BITS+sth_pkg::FRAC_EXTRA-1:0]    rd_data,
	output logic                                               idx_busy,
	output logic                                               wr_en,
	output logic [$clog2(MAX_BINS)-1:0]                        wr_addr,
	output logic [SAMPLE_BITS+sth_pkg::FRAC_EXTRA-1:0]         wr_data,
	output logic                                               push,
	output logic signed [SAMPLE_BITS-1:0]                      push_value,
	output logic [$clog2(MAX_BINS)-1:0]                        push_index,
	output logic                                               push_last
);
	import sth_pkg::*;

	localparam int IW = $clog2(MAX_BINS);
	localparam int SW = SAMPLE_BITS + FRAC_EXTRA;
	localparam int DW = SW + 1;
	localparam int PW = DW + ALPHA_W + 1;
	localparam int RW = SW + 1;

	// stage 1: store data arrives
	logic                          v_s1;
	item_op_t                      op_s1;
	logic [IW-1:0]                 idx_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          byp_hit_s1;
	logic signed [SW-1:0]          byp_data_s1;

	// stage 2: weight multiply
	logic                 v_s2;
	item_op_t             op_s2;
	logic [IW-1:0]        idx_s2;
	logic signed [SW-1:0] x_s2;
	logic signed [SW-1:0] s_s2;
	logic signed [DW-1:0] diff_s2;

	// stage 3: update and write back
	logic                 v_s3;
	item_op_t             op_s3;
	logic [IW-1:0]        idx_s3;
	logic signed [SW-1:0] x_s3;
	logic signed [SW-1:0] s_s3;
	logic signed [PW-1:0] prod_s3;

	// stage 4: round to output format
	logic                 v_s4;
	logic                 last_s4;
	logic [IW-1:0]        idx_s4;
	logic signed [SW-1:0] new_s4;

	logic signed [SW-1:0] x_wide;
	logic signed [SW-1:0] s_old;
	logic signed [DW-1:0] diff_c;
	logic signed [PW-1:0] prod_c;
	logic signed [PW-1:0] step_c;
	logic signed [SW-1:0] avg_c;
	logic signed [SW-1:0] new_c;
	logic signed [RW-1:0] rnd_c;
	logic signed [SAMPLE_BITS:0] rnd_top;

	// stage 1
	assign x_wide = {x_s1, {FRAC_EXTRA{1'b0}}};
	assign s_old  = byp_hit_s1 ? byp_data_s1 : $signed(rd_data);
	assign diff_c = DW'(x_wide) - DW'(s_old);

	// stage 2
	assign prod_c = PW'($signed({1'b0, alpha})) * PW'(diff_s2);

	// stage 3
	assign step_c = (prod_s3 + PW'(ALPHA_HALF)) >>> ALPHA_FRAC;
	assign avg_c  = s_s3 + step_c[SW-1:0];

	always_comb begin
		priority if (op_s3.use_x) begin
			new_c = x_s3;
		end else if (op_s3.take_max) begin
			new_c = (x_s3 > s_s3) ? x_s3 : s_s3;
		end else begin
			new_c = avg_c;
		end
	end

	assign wr_en   = v_s3;
	assign wr_addr = idx_s3;
	assign wr_data = new_c;

	// entries still in stages 1 and 2 have not been written back yet
	assign idx_busy = (v_s1 && (idx_s1 == cand_idx)) || (v_s2 && (idx_s2 == cand_idx));

	// stage 4: nearest, ties up, then saturate
	assign rnd_c   = (RW'(new_s4) + RW'(1 << (FRAC_EXTRA - 1))) >>> FRAC_EXTRA;
	assign rnd_top = rnd_c[SAMPLE_BITS:0];

	always_comb begin
		if (rnd_top[SAMPLE_BITS] != rnd_top[SAMPLE_BITS-1]) begin
			push_value = rnd_top[SAMPLE_BITS]
				? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
				: {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else begin
			push_value = rnd_top[SAMPLE_BITS-1:0];
		end
	end

	assign push       = v_s4;
	assign push_index = idx_s4;
	assign push_last  = last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else begin
			v_s1       <= accept;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			// read and write of the same entry at one edge: take the new value
			byp_hit_s1 <= accept && v_s3 && (cand_idx == idx_s3);
		end
	end

	always_ff @(posedge clk) begin
		op_s1       <= op;
		idx_s1      <= cand_idx;
		x_s1        <= bin_power;
		byp_data_s1 <= new_c;

		op_s2   <= op_s1;
		idx_s2  <= idx_s1;
		x_s2    <= x_wide;
		s_s2    <= s_old;
		diff_s2 <= diff_c;

		op_s3   <= op_s2;
		idx_s3  <= idx_s2;
		x_s3    <= x_s2;
		s_s3    <= s_s2;
		prod_s3 <= prod_c;

		last_s4 <= op_s3.last;
		idx_s4  <= idx_s3;
		new_s4  <= new_c;
	end
endmodule

`default_nettype wire

@@ rtl/sth_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sth_out_fifo
// result buffer with space reserved for every word inside the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module sth_out_fifo #(
	parameter int MAX_BINS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              reserve,
	input  wire logic                              push,
	input  wire logic signed [SAMPLE_BITS-1:0]     push_value,
	input  wire logic [$clog2(MAX_BINS)-1:0]       push_index,
	input  wire logic                              push_last,
	output logic                                   has_room,
	sth_trace_if.source                            trace
);
	import sth_pkg::*;

	localparam int IW = $clog2(MAX_BINS);
	localparam int CW = OUT_PTR_W + 1;

	logic signed [SAMPLE_BITS-1:0] value_q [OUT_DEPTH];
	logic [IW-1:0]                 index_q [OUT_DEPTH];
	logic                          last_q  [OUT_DEPTH];

	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]        occ_q;
	logic [CW-1:0]        rsv_q;
	logic                 pop;

	assign trace.valid       = occ_q != '0;
	assign trace.trace_value = value_q[rd_ptr_q];
	assign trace.bin_index   = index_q[rd_ptr_q];
	assign trace.frame_last  = last_q[rd_ptr_q];

	assign pop      = trace.valid && trace.ready;
	// words in flight plus words waiting never exceed the buffer
	assign has_room = rsv_q < CW'(OUT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			rsv_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			occ_q <= occ_q + CW'(push) - CW'(pop);
			rsv_q <= rsv_q + CW'(reserve) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			value_q[wr_ptr_q] <= push_value;
			index_q[wr_ptr_q] <= push_index;
			last_q[wr_ptr_q]  <= push_last;
		end
	end
endmodule

`default_nettype wire

@@ rtl/spectrum_trace_hold_average.sv @@
// ----------------------------------------------------------------------------
// spectrum_trace_hold_average
// per-bin live / max-hold / exponential-average trace for streamed spectra
// ----------------------------------------------------------------------------
// spectrum takes one signed Q8.8 dB magnitude bin per word; trace returns one
// word per bin: the updated trace value (Q8.8), the bin position in the frame
// and a last-of-frame flag. The cfg port writes trace_mode, frame_length and
// avg_alpha; write only while no bins are in flight.
// An accepted bin runs through the update pipeline and the result buffer
// before its result shows on trace. Throughput is one bin per cycle for frame
// lengths of 3 and more while the result buffer has room. The trace store is
// a single-port-write RAM updated by a 4-stage read-modify-write pipeline;
// a bin whose entry is still in its first two stages waits, so at frame
// lengths of 2 and 1 a bin is held until the last one on its entry leaves them.
// Reset clears the bin counter and the priming flag; the first frame after
// reset or a frame_length write loads the store directly, so no clearing pass
// is needed. A stalled receiver fills an 8-word result buffer; spectrum.ready
// drops when the buffer plus the pipeline hold 8 words or its bin must wait.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_trace_hold_average #(
	parameter int MAX_BINS    = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	sth_bin_if.sink                                spectrum,
	sth_trace_if.source                            trace,
	input  wire logic                              cfg_write_en,
	input  wire logic [sth_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sth_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sth_pkg::*;

	localparam int IW = $clog2(MAX_BINS);
	localparam int SW = SAMPLE_BITS + FRAC_EXTRA;

	logic                          accept;
	logic                          has_room;
	logic                          idx_busy;
	logic [IW-1:0]                 cand_idx;
	item_op_t                      op;
	logic [ALPHA_W-1:0]            alpha;
	logic [SW-1:0]                 rd_data;
	logic                          wr_en;
	logic [IW-1:0]                 wr_addr;
	logic [SW-1:0]                 wr_data;
	logic                          push;
	logic signed [SAMPLE_BITS-1:0] push_value;
	logic [IW-1:0]                 push_index;
	logic                          push_last;

	sth_ctrl #(
		.MAX_BINS (MAX_BINS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (spectrum.valid),
		.has_room     (has_room),
		.idx_busy     (idx_busy),
		.in_ready     (spectrum.ready),
		.accept       (accept),
		.cand_idx     (cand_idx),
		.op           (op),
		.alpha        (alpha)
	);

	sth_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_BINS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (cand_idx),
		.rdata (rd_data)
	);

	sth_update #(
		.MAX_BINS    (MAX_BINS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cand_idx   (cand_idx),
		.op         (op),
		.bin_power  (spectrum.bin_power),
		.alpha      (alpha),
		.rd_data    (rd_data),
		.idx_busy   (idx_busy),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.push       (push),
		.push_value (push_value),
		.push_index (push_index),
		.push_last  (push_last)
	);

	sth_out_fifo #(
		.MAX_BINS    (MAX_BINS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.reserve    (accept),
		.push       (push),
		.push_value (push_value),
		.push_index (push_index),
		.push_last  (push_last),
		.has_room   (has_room),
		.trace      (trace)
	);
endmodule

`default_nettype wire

@@ rtl/sth_checker.sv @@
// ----------------------------------------------------------------------------
// sth_checker
// port-level checks of the spectrum trace block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "spectrum_trace_hold_average_assert.svh"

module sth_checker #(
	parameter int MAX_BINS = 1024
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [$clog2(MAX_BINS)-1:0]     bin_index,
	input wire logic                            frame_last,
	input wire logic                            cfg_write_en,
	input wire logic [sth_pkg::CFG_IDX_W-1:0]   cfg_index
);
	import sth_pkg::*;

	localparam int IW = $clog2(MAX_BINS);
	localparam int PW = OUT_PTR_W + 2;

	logic          in_acc;
	logic          out_acc;
	logic [IW-1:0] prev_idx_q;
	logic          prev_last_q;
	logic          len_wr_q;
	logic [PW-1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_idx_q  <= '0;
			prev_last_q <= 1'b1;
			len_wr_q    <= 1'b0;
			pending_q   <= '0;
		end else begin
			pending_q <= pending_q + PW'(in_acc) - PW'(out_acc);
			if (cfg_write_en && (cfg_index == REG_FRAME_LENGTH)) begin
				len_wr_q <= 1'b1;
			end else if (out_acc) begin
				len_wr_q <= 1'b0;
			end
			if (out_acc) begin
				prev_idx_q  <= bin_index;
				prev_last_q <= frame_last;
			end
		end
	end

	`STH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "trace word dropped while stalled")
	`STH_ASSERT_IMP(a_frame_start, out_acc && prev_last_q, bin_index == '0, "frame does not start at bin 0")
	`STH_ASSERT_IMP(a_bin_step, out_acc && !prev_last_q && !len_wr_q, bin_index == IW'(prev_idx_q + 1'b1), "bin index skipped")
	`STH_ASSERT_IMP(a_no_extra, out_acc, pending_q != '0, "trace word without an accepted bin")
endmodule

bind spectrum_trace_hold_average sth_checker #(
	.MAX_BINS (MAX_BINS)
) u_sth_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (spectrum.valid),
	.in_ready     (spectrum.ready),
	.out_valid    (trace.valid),
	.out_ready    (trace.ready),
	.bin_index    (trace.bin_index),
	.frame_last   (trace.frame_last),
	.cfg_write_en (cfg_write_en),
	.cfg_index    (cfg_index)
);

`default_nettype wire

@@ tb/spectrum_trace_hold_average_tb.sv @@
// ----------------------------------------------------------------------------
// spectrum_trace_hold_average_tb
// self-checking bench for the live / max-hold / average spectrum trace
// ----------------------------------------------------------------------------
// A directed table walks the corner cases: priming after reset, the extremes
// of the bin range, max hold, average with weights zero, one half and beyond
// one, the unused mode and frame length zero. Random phases then change the
// registers between phases and stream bins, with idle bursts on both sides,
// a long receiver hold-off and one full-size frame. Every trace word is
// compared with a bit-exact trace predictor or with the word the table gives.
// ----------------------------------------------------------------------------

module spectrum_trace_hold_average_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sth_pkg::*;

	localparam int MAX_BINS     = 1024;
	localparam int SAMPLE_BITS  = 16;
	localparam int INDEX_W      = 10;
	localparam int STORE_W      = SAMPLE_BITS + FRAC_EXTRA;
	localparam int RANDOM_ITEMS = 1000;
	localparam int IDLE_LIMIT   = 1000;
	localparam int SETTLE       = 8;
	localparam int LONG_HOLD    = 80;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	// codes the package leaves unnamed
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam logic [1:0]           MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic [INDEX_W-1:0]            index;
		logic                          last;
	} trace_word_t;

	typedef enum logic {ROW_CFG, ROW_BIN} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [CFG_IDX_W-1:0]          reg_sel;
		logic [CFG_DATA_W-1:0]         data;
		logic signed [SAMPLE_BITS-1:0] bin;
		bit                            known;
		trace_word_t                   want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sth_bin_if #(.SAMPLE_BITS(SAMPLE_BITS)) bin_if ();
	sth_trace_if #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_BINS(MAX_BINS)) trc_if ();

	spectrum_trace_hold_average #(
		.MAX_BINS(MAX_BINS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.spectrum(bin_if),
		.trace(trc_if),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state and register copies
	logic signed [STORE_W-1:0] trace_mem [MAX_BINS];
	logic [INDEX_W-1:0]        bin_pos;
	bit                        primed;
	logic [1:0]                mode_r;
	logic [10:0]               frame_len_r;
	logic [ALPHA_W-1:0]        alpha_r;

	trace_word_t expected_q [$];
	stim_row_t   directed_rows [$];

	int mismatch_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int rx_long_hold = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit known_on = 1'b0;
	trace_word_t known_word;
	logic signed [SAMPLE_BITS-1:0] prev_bin = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic trace_word_t predict_trace(input logic signed [SAMPLE_BITS-1:0] x);
		int unsigned len;
		int unsigned idx;
		longint xs;
		longint s;
		longint a;
		longint r;
		trace_word_t w;
		len = (frame_len_r == '0) ? 1 : ((frame_len_r > MAX_BINS) ? MAX_BINS : frame_len_r);
		idx = bin_pos;
		if (idx >= len)
			idx = 0;
		xs = longint'(x) <<< FRAC_EXTRA;
		s = longint'(trace_mem[idx]);
		if (primed && mode_r == MODE_MAX_HOLD) begin
			if (xs > s)
				s = xs;
		end else if (primed && mode_r == MODE_AVERAGE) begin
			a = (alpha_r > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_r);
			s = s + ((a * (xs - s) + ALPHA_HALF) >>> ALPHA_FRAC);
		end else begin
			s = xs;
		end
		trace_mem[idx] = s[STORE_W-1:0];
		r = (s + (longint'(1) <<< (FRAC_EXTRA - 1))) >>> FRAC_EXTRA;
		if (r > SAMPLE_MAX)
			r = SAMPLE_MAX;
		if (r < SAMPLE_MIN)
			r = SAMPLE_MIN;
		w.value = r[SAMPLE_BITS-1:0];
		w.index = idx[INDEX_W-1:0];
		w.last = (idx + 1 >= len);
		if (w.last) begin
			bin_pos = '0;
			primed = 1'b1;
		end else begin
			bin_pos = INDEX_W'(idx + 1);
		end
		return w;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		mismatch_count++;
		$display("mismatch in %s of trace word %0d: got %0d, expected %0d",
			field, results_seen, got, want);
	endtask

	// prediction on every accepted bin and register write, check on every trace word
	always @(posedge clk) begin : scoreboard
		trace_word_t w;
		if (arst_n) begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_TRACE_MODE: mode_r = cfg_data[1:0];
					REG_FRAME_LENGTH: begin
						frame_len_r = cfg_data[10:0];
						bin_pos = '0;
						primed = 1'b0;
					end
					REG_AVG_ALPHA: alpha_r = cfg_data;
					default: ;
				endcase
			end
			if (bin_if.valid && bin_if.ready) begin
				w = predict_trace(bin_if.bin_power);
				if (known_on)
					w = known_word;
				expected_q.push_back(w);
			end
			if (trc_if.valid && trc_if.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("presence (nothing pending)", trc_if.trace_value, 0);
				end else begin
					w = expected_q.pop_front();
					if (trc_if.trace_value !== w.value)
						report_mismatch("trace_value", trc_if.trace_value, w.value);
					if (trc_if.bin_index !== w.index)
						report_mismatch("bin_index", trc_if.bin_index, w.index);
					if (trc_if.frame_last !== w.last)
						report_mismatch("frame_last", trc_if.frame_last, w.last);
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((bin_if.valid && bin_if.ready) || (trc_if.valid && trc_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("spectrum_trace_hold_average_tb failed");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin : trace_sink
		int hold;
		hold = 0;
		trc_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (rx_long_hold > 0) begin
				rx_long_hold--;
				trc_if.ready <= 1'b0;
			end else if (hold > 0) begin
				hold--;
				trc_if.ready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 7) - 1;
				trc_if.ready <= 1'b0;
			end else begin
				trc_if.ready <= 1'b1;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_bin(input logic signed [SAMPLE_BITS-1:0] x);
		int gap;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			bin_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bin_if.valid <= 1'b1;
		bin_if.bin_power <= x;
		do @(posedge clk); while (!bin_if.ready);
		@(negedge clk);
		prev_bin = x;
	endtask

	task automatic drain_results();
		bin_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.reg_sel = sel;
		row.data = data;
		row.bin = '0;
		row.known = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_bin(input logic signed [SAMPLE_BITS-1:0] x);
		stim_row_t row;
		row.kind = ROW_BIN;
		row.reg_sel = '0;
		row.data = '0;
		row.bin = x;
		row.known = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_known(input logic signed [SAMPLE_BITS-1:0] x,
			input logic signed [SAMPLE_BITS-1:0] v, input logic [INDEX_W-1:0] i,
			input logic l);
		stim_row_t row;
		row.kind = ROW_BIN;
		row.reg_sel = '0;
		row.data = '0;
		row.bin = x;
		row.known = 1'b1;
		row.want.value = v;
		row.want.index = i;
		row.want.last = l;
		directed_rows.push_back(row);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_bin();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX[SAMPLE_BITS-1:0];
			1: return SAMPLE_MIN[SAMPLE_BITS-1:0];
			2: return $urandom_range(0, 2) - 1;
			3, 4, 5: return $urandom;
			default: return prev_bin + ($urandom_range(0, 512) - 256);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_length();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return 3;
			default: return $urandom_range(4, 24);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_alpha();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 1;
			2: return ALPHA_ONE - 1;
			3: return ALPHA_ONE;
			4: return $urandom_range(ALPHA_ONE + 1, (1 << ALPHA_W) - 1);
			default: return $urandom_range(1, ALPHA_ONE - 1);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_mode();
		logic [CFG_DATA_W-1:0] data;
		data = $urandom_range(0, 3);
		// junk above the mode field now and then
		if ($urandom_range(0, 3) == 0)
			data[CFG_DATA_W-1:2] = $urandom;
		return data;
	endfunction

	initial begin : stimulus
		int n;
		int phase;
		int random_items;
		bit big_frame;
		for (int k = 0; k < MAX_BINS; k++)
			trace_mem[k] = '0;
		bin_pos = '0;
		primed = 1'b0;
		mode_r = MODE_LIVE;
		frame_len_r = 11'(MAX_BINS);
		alpha_r = ALPHA_RESET;

		arst_n = 1'b0;
		bin_if.valid <= 1'b0;
		bin_if.bin_power <= '0;
		cfg_write_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// priming after reset at the default frame length
		add_known(16'sd100, 16'sd100, 0, 1'b0);
		add_known(-16'sd1, -16'sd1, 1, 1'b0);
		add_cfg(REG_FRAME_LENGTH, 4);
		add_known(16'sh7fff, 16'sh7fff, 0, 1'b0);
		add_known(16'sh8000, 16'sh8000, 1, 1'b0);
		add_known(16'sd0, 16'sd0, 2, 1'b0);
		add_known(16'sd1, 16'sd1, 3, 1'b1);
		add_cfg(REG_TRACE_MODE, MODE_MAX_HOLD);
		add_known(16'sd0, 16'sh7fff, 0, 1'b0);
		add_known(16'sh7fff, 16'sh7fff, 1, 1'b0);
		add_known(-16'sd5, 16'sd0, 2, 1'b0);
		add_known(16'sh8000, 16'sd1, 3, 1'b1);
		// weight above one saturates to one: the average follows the bin
		add_cfg(REG_AVG_ALPHA, ALPHA_ONE + 1);
		add_cfg(REG_TRACE_MODE, MODE_AVERAGE);
		add_known(16'sh8000, 16'sh8000, 0, 1'b0);
		add_known(16'sh7fff, 16'sh7fff, 1, 1'b0);
		add_bin(16'sd256);
		add_bin(-16'sd256);
		// zero weight freezes the store
		add_cfg(REG_AVG_ALPHA, 0);
		add_known(16'sd12345, 16'sh8000, 0, 1'b0);
		add_bin(-16'sd100);
		add_cfg(REG_AVG_ALPHA, ALPHA_HALF);
		add_bin(16'sd1000);
		add_bin(-16'sd1000);
		add_cfg(REG_UNUSED, (1 << CFG_DATA_W) - 1);
		add_cfg(REG_TRACE_MODE, MODE_UNUSED);
		add_known(16'sd77, 16'sd77, 0, 1'b0);
		// zero length acts as one bin per frame
		add_cfg(REG_FRAME_LENGTH, 0);
		add_known(-16'sd7, -16'sd7, 0, 1'b1);
		add_known(16'sd5, 16'sd5, 0, 1'b1);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_CFG) begin
				drain_results();
				write_reg(directed_rows[k].reg_sel, directed_rows[k].data);
			end else begin
				known_on = directed_rows[k].known;
				known_word = directed_rows[k].want;
				send_bin(directed_rows[k].bin);
				known_on = 1'b0;
			end
		end

		phase = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain_results();
			big_frame = (phase == 4);
			if (big_frame) begin
				write_reg(REG_FRAME_LENGTH, $urandom_range(0, 1) ? MAX_BINS :
					$urandom_range(MAX_BINS + 1, 2047));
				n = MAX_BINS + $urandom_range(16, 64);
			end else begin
				if (phase == 0 || $urandom_range(0, 1) == 1)
					write_reg(REG_FRAME_LENGTH, pick_length());
				n = $urandom_range(20, 80);
			end
			write_reg(REG_TRACE_MODE, pick_mode());
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_AVG_ALPHA, pick_alpha());
			// receiver holds off while bins keep coming, so the input stalls
			if (phase == 1) begin
				rx_long_hold = LONG_HOLD;
				tx_idle_on = 1'b0;
			end
			repeat (n) begin
				if (random_items >= RANDOM_ITEMS * 85 / 100) begin
					tx_idle_on = 1'b0;
					rx_idle_on = 1'b0;
				end
				send_bin(pick_bin());
				random_items++;
			end
			if (phase == 1)
				tx_idle_on = 1'b1;
			phase++;
		end

		drain_results();
		repeat (4 * SETTLE) @(negedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("spectrum_trace_hold_average_tb passed");
		end else begin
			$display("spectrum_trace_hold_average_tb failed");
		end
		$finish;
	end

endmodule
